>>> src/prrts_pkg.sv
// Shared types, codes and defaults for the priority round-robin task scheduler.
`default_nettype none
package prrts_pkg;

  localparam int TASKS_DEF = 16;

  typedef enum logic [2:0] {
    K_CREATE = 3'd0,
    K_DELETE = 3'd1,
    K_DELAY  = 3'd2,
    K_TICK   = 3'd3,
    K_YIELD  = 3'd4
  } kind_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_BAD   = 2'd1;
  localparam logic [1:0] ST_NOCUR = 2'd2;

  localparam logic [1:0] WH_NONE  = 2'd0;
  localparam logic [1:0] WH_READY = 2'd1;
  localparam logic [1:0] WH_DELAY = 2'd2;

  localparam logic [1:0] RING_DELAY = 2'd3;
  localparam logic [1:0] PRIO_BAD   = 2'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CRE_SET,
    OP_DEL_SET,
    OP_DLY_SET,
    OP_UL_RD,
    OP_UL_WR,
    OP_RING_DLY,
    OP_RING_LVL,
    OP_AP_RD,
    OP_AP_WR1,
    OP_AP_WR2,
    OP_TICK,
    OP_SW_INIT,
    OP_SW_TEST,
    OP_SW_ADV,
    OP_SW_ROOT,
    OP_SW_STEP1,
    OP_SW_STEP2,
    OP_ST_BAD,
    OP_ST_NOCUR
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic create_ok;
    logic delete_ok;
    logic delay_ok;
    logic walk_go;
    logic wake_hit;
  } stat_t;

endpackage
`default_nettype wire

>>> src/prrts_dp.sv
// Datapath: link arrays, task tables, ring counts, tick counter and walk registers.
`default_nettype none
module prrts_dp import prrts_pkg::*; #(
  parameter int MAX_TASKS = TASKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  input  wire logic [3:0]  in_task_id,
  input  wire logic [1:0]  in_priority_req,
  input  wire logic [31:0] in_delay_ticks,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data,
  output logic [3:0]       out_running_task,
  output logic             out_running_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_tick_now
);

  localparam int NN = MAX_TASKS + 4;
  localparam int NW = $clog2(NN);
  localparam int TW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam logic [NW-1:0] MT_N = NW'(MAX_TASKS);

  logic [NW-1:0] next_r [NN];
  logic [NW-1:0] prev_r [NN];
  logic [1:0]    level_r [MAX_TASKS];
  logic [1:0]    where_r [MAX_TASKS];
  logic [31:0]   wake_r [MAX_TASKS];
  logic [CW-1:0] cnt_r [4];
  logic [NW-1:0] cur_r, a_r, p_r, n_r, w_r, nx_r;
  logic [1:0]    ring_r;
  logic [CW-1:0] left_r;
  logic          chg_r;
  logic [31:0]   tick_r;
  logic [7:0]    step_r;
  logic [1:0]    st_r;
  logic [3:0]    id_r;
  logic [1:0]    prio_r;
  logic [31:0]   dly_r;

  logic [TW-1:0] id_idx, cur_idx, w_idx, a_idx;
  logic [1:0]    where_id;
  logic          cur_task;

  function automatic logic [NW-1:0] root(input logic [1:0] ring);
    return MT_N + NW'(ring);
  endfunction

  assign id_idx   = TW'(id_r);
  assign cur_idx  = TW'(cur_r);
  assign w_idx    = TW'(w_r);
  assign a_idx    = TW'(a_r);
  assign where_id = where_r[id_idx];
  assign cur_task = (cur_r < MT_N);

  always_comb begin
    stat.create_ok = (32'(id_r) < MAX_TASKS) && (prio_r != PRIO_BAD) && (where_id == WH_NONE);
    stat.delete_ok = (32'(id_r) < MAX_TASKS) && (where_id != WH_NONE);
    stat.delay_ok  = cur_task && (where_r[cur_idx] == WH_READY);
    stat.walk_go   = (left_r != '0) && (w_r < MT_N);
    stat.wake_hit  = tick_r > wake_r[w_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NN; i++) begin
        next_r[i] <= NW'(i);
        prev_r[i] <= NW'(i);
      end
      for (int i = 0; i < MAX_TASKS; i++) begin
        where_r[i] <= WH_NONE;
      end
      for (int i = 0; i < 4; i++) begin
        cnt_r[i] <= '0;
      end
      cur_r  <= root(2'd0);
      chg_r  <= 1'b1;
      tick_r <= '0;
      step_r <= 8'd1;
      st_r   <= ST_OK;
    end else begin
      if (cfg_wr_en) begin
        step_r <= cfg_wr_data;
      end
      if (cmd.load) begin
        id_r   <= in_task_id;
        prio_r <= in_priority_req;
        dly_r  <= in_delay_ticks;
        st_r   <= ST_OK;
      end
      case (cmd.op)
        OP_CRE_SET: begin
          level_r[id_idx] <= prio_r;
          where_r[id_idx] <= WH_READY;
          chg_r  <= 1'b1;
          a_r    <= NW'(id_r);
          ring_r <= prio_r;
        end
        OP_DEL_SET: begin
          ring_r <= (where_id == WH_DELAY) ? RING_DELAY : level_r[id_idx];
          where_r[id_idx] <= WH_NONE;
          chg_r <= 1'b1;
          a_r   <= NW'(id_r);
        end
        OP_DLY_SET: begin
          // Wake time is compensated by the size of the ring the task leaves.
          wake_r[cur_idx] <= tick_r + dly_r + 32'd1 - 32'(cnt_r[level_r[cur_idx]]);
          where_r[cur_idx] <= WH_DELAY;
          chg_r  <= 1'b1;
          a_r    <= cur_r;
          ring_r <= level_r[cur_idx];
        end
        OP_UL_RD: begin
          p_r <= prev_r[a_r];
          n_r <= next_r[a_r];
        end
        OP_UL_WR: begin
          next_r[p_r] <= n_r;
          prev_r[n_r] <= p_r;
          if (cnt_r[ring_r] != '0) begin
            cnt_r[ring_r] <= cnt_r[ring_r] - CW'(1);
          end
        end
        OP_RING_DLY: ring_r <= RING_DELAY;
        OP_RING_LVL: ring_r <= level_r[a_idx];
        OP_AP_RD: begin
          p_r <= prev_r[root(ring_r)];
          next_r[a_r] <= root(ring_r);
        end
        OP_AP_WR1: begin
          prev_r[a_r] <= p_r;
          next_r[p_r] <= a_r;
        end
        OP_AP_WR2: begin
          prev_r[root(ring_r)] <= a_r;
          cnt_r[ring_r] <= cnt_r[ring_r] + CW'(1);
        end
        OP_TICK: tick_r <= tick_r + 32'(step_r);
        OP_SW_INIT: begin
          left_r <= cnt_r[RING_DELAY];
          w_r    <= next_r[root(RING_DELAY)];
        end
        OP_SW_TEST: begin
          nx_r   <= next_r[w_r];
          a_r    <= w_r;
          ring_r <= RING_DELAY;
          if (stat.wake_hit) begin
            chg_r <= 1'b1;
            where_r[w_idx] <= WH_READY;
          end
        end
        OP_SW_ADV: begin
          w_r    <= nx_r;
          left_r <= left_r - CW'(1);
        end
        OP_SW_ROOT: begin
          if (chg_r) begin
            if (cnt_r[2] != '0) begin
              cur_r <= root(2'd2);
            end else if (cnt_r[1] != '0) begin
              cur_r <= root(2'd1);
            end else begin
              cur_r <= root(2'd0);
            end
            chg_r <= 1'b0;
          end
        end
        OP_SW_STEP1: cur_r <= next_r[cur_r];
        OP_SW_STEP2: begin
          if (!cur_task) begin
            cur_r <= next_r[cur_r];
          end
        end
        OP_ST_BAD:   st_r <= ST_BAD;
        OP_ST_NOCUR: st_r <= ST_NOCUR;
        default: ;
      endcase
    end
  end

  assign out_running_task  = cur_task ? 4'(cur_r) : 4'd0;
  assign out_running_valid = cur_task;
  assign out_status        = st_r;
  assign out_tick_now      = tick_r;

endmodule
`default_nettype wire

>>> src/prrts_ctrl.sv
// Controller: sequences ring edits, the delay-list walk and the switch that a word calls for.
`default_nettype none
module prrts_ctrl import prrts_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_kind,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire stat_t      stat,
  output cmd_t            cmd
);

  typedef enum logic [21:0] {
    S_IDLE  = 22'h000001,
    S_DEC   = 22'h000002,
    S_CSET  = 22'h000004,
    S_DSET  = 22'h000008,
    S_LSET  = 22'h000010,
    S_ULRD  = 22'h000020,
    S_ULWR  = 22'h000040,
    S_RDLY  = 22'h000080,
    S_RLVL  = 22'h000100,
    S_APRD  = 22'h000200,
    S_APW1  = 22'h000400,
    S_APW2  = 22'h000800,
    S_TICK  = 22'h001000,
    S_SWI   = 22'h002000,
    S_SWT   = 22'h004000,
    S_SWA   = 22'h008000,
    S_ROOT  = 22'h010000,
    S_ST1   = 22'h020000,
    S_ST2   = 22'h040000,
    S_BAD   = 22'h080000,
    S_NOCUR = 22'h100000,
    S_DONE  = 22'h200000
  } state_t;

  state_t      state_r, state_nxt;
  logic [2:0]  kind_r, kind_nxt;
  logic        walk_r, walk_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= K_YIELD;
      walk_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      walk_r  <= walk_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_DONE);

  always_comb begin
    state_nxt = state_r;
    kind_nxt  = kind_r;
    walk_nxt  = walk_r;
    cmd.load  = 1'b0;
    cmd.op    = OP_NONE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          kind_nxt  = in_kind;
          walk_nxt  = 1'b0;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        case (kind_r)
          K_CREATE: state_nxt = stat.create_ok ? S_CSET : S_BAD;
          K_DELETE: state_nxt = stat.delete_ok ? S_DSET : S_BAD;
          K_DELAY:  state_nxt = stat.delay_ok ? S_LSET : S_NOCUR;
          K_TICK:   state_nxt = S_TICK;
          K_YIELD:  state_nxt = S_SWI;
          default:  state_nxt = S_BAD;
        endcase
      end
      S_CSET: begin cmd.op = OP_CRE_SET; state_nxt = S_APRD; end
      S_DSET: begin cmd.op = OP_DEL_SET; state_nxt = S_ULRD; end
      S_LSET: begin cmd.op = OP_DLY_SET; state_nxt = S_ULRD; end
      S_ULRD: begin cmd.op = OP_UL_RD; state_nxt = S_ULWR; end
      S_ULWR: begin
        cmd.op = OP_UL_WR;
        if (walk_r) begin
          state_nxt = S_RLVL;
        end else if (kind_r == K_DELETE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_RDLY;
        end
      end
      S_RDLY: begin cmd.op = OP_RING_DLY; state_nxt = S_APRD; end
      S_RLVL: begin cmd.op = OP_RING_LVL; state_nxt = S_APRD; end
      S_APRD: begin cmd.op = OP_AP_RD; state_nxt = S_APW1; end
      S_APW1: begin cmd.op = OP_AP_WR1; state_nxt = S_APW2; end
      S_APW2: begin
        cmd.op = OP_AP_WR2;
        if (walk_r) begin
          state_nxt = S_SWA;
        end else if (kind_r == K_CREATE) begin
          state_nxt = S_DONE;
        end else begin
          state_nxt = S_SWI;
        end
      end
      S_TICK: begin cmd.op = OP_TICK; state_nxt = S_SWI; end
      S_SWI: begin
        cmd.op    = OP_SW_INIT;
        walk_nxt  = 1'b1;
        state_nxt = S_SWT;
      end
      S_SWT: begin
        // Each task that was delayed when the switch began is visited once.
        if (stat.walk_go) begin
          cmd.op    = OP_SW_TEST;
          state_nxt = stat.wake_hit ? S_ULRD : S_SWA;
        end else begin
          state_nxt = S_ROOT;
        end
      end
      S_SWA:  begin cmd.op = OP_SW_ADV; state_nxt = S_SWT; end
      S_ROOT: begin
        cmd.op    = OP_SW_ROOT;
        walk_nxt  = 1'b0;
        state_nxt = S_ST1;
      end
      S_ST1:   begin cmd.op = OP_SW_STEP1; state_nxt = S_ST2; end
      S_ST2:   begin cmd.op = OP_SW_STEP2; state_nxt = S_DONE; end
      S_BAD:   begin cmd.op = OP_ST_BAD; state_nxt = S_DONE; end
      S_NOCUR: begin cmd.op = OP_ST_NOCUR; state_nxt = S_DONE; end
      S_DONE: begin
        if (out_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> src/priority_round_robin_task_scheduler.sv
// Top level of the priority round-robin task scheduler.
// One word is handled at a time and gives exactly one result word:
// - A create appends the task to its ring; a delete unlinks it.
// - A rejected word, or a delay with no ready task, only sets the status.
// - A yield runs a switch. A tick advances the count and a delay moves the
//   running task to the delay list; each then runs a switch.
// - Each switch visits the delayed tasks and moves each one that wakes back
//   to its ring.
// The controller walks the link arrays through one read and one write port
// per array each cycle. A new word is taken once the previous result has been
// taken.
`default_nettype none
module priority_round_robin_task_scheduler import prrts_pkg::*; #(
  parameter int MAX_TASKS = TASKS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_kind,
  input  wire logic [3:0]  in_task_id,
  input  wire logic [1:0]  in_priority_req,
  input  wire logic [31:0] in_delay_ticks,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_running_task,
  output logic             out_running_valid,
  output logic [1:0]       out_status,
  output logic [31:0]      out_tick_now,
  input  wire logic        cfg_wr_en,
  input  wire logic [7:0]  cfg_wr_data
);

  cmd_t  cmd;
  stat_t stat;

  prrts_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_kind   (in_kind),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  prrts_dp #(.MAX_TASKS(MAX_TASKS)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_task_id        (in_task_id),
    .in_priority_req   (in_priority_req),
    .in_delay_ticks    (in_delay_ticks),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .out_running_task  (out_running_task),
    .out_running_valid (out_running_valid),
    .out_status        (out_status),
    .out_tick_now      (out_tick_now)
  );

endmodule
`default_nettype wire

>>> src/prrts_check.sv
// Port-level checker for the scheduler and its bind to the top level.
`default_nettype none
module prrts_check (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [3:0]  out_running_task,
  input wire logic        out_running_valid,
  input wire logic [1:0]  out_status,
  input wire logic [31:0] out_tick_now
);

  // The block never takes a new word while a result is still pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while a result is pending");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_tick_now) && $stable(out_status))
    else $error("result changed while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3)
    else $error("undefined status code");

  a_root_task: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_running_valid |-> out_running_task == 4'd0)
    else $error("task slot shown for an empty ring");

endmodule

bind priority_round_robin_task_scheduler prrts_check u_check (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_ready          (in_ready),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_running_task  (out_running_task),
  .out_running_valid (out_running_valid),
  .out_status        (out_status),
  .out_tick_now      (out_tick_now)
);
`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the priority round-robin task scheduler.
`timescale 1ns / 100ps
module tb;
  import prrts_pkg::*;

  localparam int NSLOT = 16;
  localparam int ROOT0 = NSLOT;
  localparam int DELAY_ROOT = NSLOT + 3;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 200;
  localparam int HOLD_CYCLES = 400;
  localparam logic [2:0] K_SPARE = 3'd5;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  id;
    logic [1:0]  prio;
    logic [31:0] dly;
  } op_word_t;

  typedef struct {
    logic [3:0]  task_id;
    logic        valid;
    logic [1:0]  status;
    logic [31:0] tick;
  } sched_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] in_kind = '0;
  logic [3:0] in_task_id = '0;
  logic [1:0] in_priority_req = '0;
  logic [31:0] in_delay_ticks = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_running_task;
  logic out_running_valid;
  logic [1:0] out_status;
  logic [31:0] out_tick_now;
  logic cfg_wr_en = 1'b0;
  logic [7:0] cfg_wr_data = '0;

  priority_round_robin_task_scheduler dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_kind(in_kind), .in_task_id(in_task_id),
    .in_priority_req(in_priority_req), .in_delay_ticks(in_delay_ticks),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_running_task(out_running_task), .out_running_valid(out_running_valid),
    .out_status(out_status), .out_tick_now(out_tick_now),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scheduler shadow state.
  int          link_nxt[NSLOT+4];
  int          link_prv[NSLOT+4];
  logic [1:0]  slot_level[NSLOT];
  logic [1:0]  slot_where[NSLOT];
  logic [31:0] slot_wake[NSLOT];
  int          ring_len[4];
  int          cur_node;
  logic        rings_dirty;
  logic [31:0] ticks;
  logic [7:0]  tick_step;

  op_word_t    op_queue[$];
  sched_word_t sched_expected[$];
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_req = 0;
  int          hold_left = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;
  bit          in_taken = 0;

  function automatic void ring_append(int ring, int node);
    int root, tail;
    root = ROOT0 + ring;
    tail = link_prv[root];
    link_nxt[node] = root;
    link_prv[node] = tail;
    link_nxt[tail] = node;
    link_prv[root] = node;
    ring_len[ring]++;
  endfunction

  function automatic void ring_unlink(int ring, int node);
    int p, n;
    p = link_prv[node];
    n = link_nxt[node];
    link_nxt[p] = n;
    link_prv[n] = p;
    if (ring_len[ring] != 0) ring_len[ring]--;
  endfunction

  function automatic void reschedule();
    int left, node, nx;
    left = ring_len[RING_DELAY];
    node = link_nxt[DELAY_ROOT];
    // Only the tasks delayed when the switch began are visited.
    while (left != 0 && node < NSLOT) begin
      nx = link_nxt[node];
      if (ticks > slot_wake[node]) begin
        rings_dirty = 1'b1;
        ring_unlink(RING_DELAY, node);
        ring_append(slot_level[node], node);
        slot_where[node] = WH_READY;
      end
      node = nx;
      left--;
    end
    if (rings_dirty) begin
      if (ring_len[2] != 0) cur_node = ROOT0 + 2;
      else if (ring_len[1] != 0) cur_node = ROOT0 + 1;
      else cur_node = ROOT0;
      rings_dirty = 1'b0;
    end
    nx = link_nxt[cur_node];
    if (nx >= NSLOT) nx = link_nxt[nx];
    cur_node = nx;
  endfunction

  function automatic sched_word_t schedule_op(op_word_t w);
    sched_word_t r;
    logic [1:0] st;
    int c;
    st = ST_OK;
    case (w.kind)
      K_CREATE: begin
        if (w.prio == PRIO_BAD || slot_where[w.id] != WH_NONE) begin
          st = ST_BAD;
        end else begin
          slot_level[w.id] = w.prio;
          ring_append(w.prio, w.id);
          slot_where[w.id] = WH_READY;
          rings_dirty = 1'b1;
        end
      end
      K_DELETE: begin
        if (slot_where[w.id] == WH_NONE) begin
          st = ST_BAD;
        end else begin
          ring_unlink(slot_where[w.id] == WH_DELAY ? RING_DELAY : slot_level[w.id], w.id);
          slot_where[w.id] = WH_NONE;
          rings_dirty = 1'b1;
        end
      end
      K_DELAY: begin
        c = cur_node;
        if (c >= NSLOT || slot_where[c] != WH_READY) begin
          st = ST_NOCUR;
        end else begin
          slot_wake[c] = ticks + w.dly + 32'd1 - 32'(ring_len[slot_level[c]]);
          ring_unlink(slot_level[c], c);
          ring_append(RING_DELAY, c);
          slot_where[c] = WH_DELAY;
          rings_dirty = 1'b1;
          reschedule();
        end
      end
      K_TICK: begin
        ticks = ticks + 32'(tick_step);
        reschedule();
      end
      K_YIELD: reschedule();
      default: st = ST_BAD;
    endcase
    r.valid = cur_node < NSLOT;
    r.task_id = r.valid ? 4'(cur_node) : 4'd0;
    r.status = st;
    r.tick = ticks;
    return r;
  endfunction

  // Input driver: new words go out on the falling edge.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 0;
      if (op_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        in_valid <= 1'b1;
        in_kind <= op_queue[0].kind;
        in_task_id <= op_queue[0].id;
        in_priority_req <= op_queue[0].prio;
        in_delay_ticks <= op_queue[0].dly;
        void'(op_queue.pop_front());
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result ready, with an optional long hold-off counted here.
  always @(negedge clk) begin
    if (hold_req && hold_left == 0) begin
      hold_left = HOLD_CYCLES;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: predicts on input acceptance and checks each result word.
  always @(posedge clk) begin
    op_word_t w;
    sched_word_t e, a;
    bit moved;
    if (rst_n) begin
      moved = 0;
      if (in_valid && in_ready) begin
        w.kind = in_kind; w.id = in_task_id; w.prio = in_priority_req;
        w.dly = in_delay_ticks;
        sched_expected.push_back(schedule_op(w));
        in_taken = 1;
        moved = 1;
      end
      if (out_valid && out_ready) begin
        moved = 1;
        a.task_id = out_running_task; a.valid = out_running_valid;
        a.status = out_status; a.tick = out_tick_now;
        if (sched_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result word: task %0d", a.task_id);
        end else begin
          e = sched_expected.pop_front();
          if (e.task_id !== a.task_id || e.valid !== a.valid ||
              e.status !== a.status || e.tick !== a.tick) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: exp task %0d valid %0b status %0d tick %0d, got %0d %0b %0d %0d",
                       e.task_id, e.valid, e.status, e.tick,
                       a.task_id, a.valid, a.status, a.tick);
          end
        end
      end
      if (moved || (!in_valid && sched_expected.size() == 0)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  function automatic op_word_t make_op(logic [2:0] k, int id, int prio, logic [31:0] dly);
    op_word_t w;
    w.kind = k; w.id = 4'(id); w.prio = 2'(prio); w.dly = dly;
    return w;
  endfunction

  function automatic op_word_t random_op();
    int pick;
    logic [31:0] d;
    pick = $urandom_range(99);
    d = ($urandom_range(9) == 0) ? $urandom() : 32'($urandom_range(12));
    if (pick < 28)
      return make_op(K_CREATE, $urandom_range(15),
                     ($urandom_range(19) == 0) ? 3 : $urandom_range(2), d);
    else if (pick < 38) return make_op(K_DELETE, $urandom_range(15), $urandom_range(3), d);
    else if (pick < 58) return make_op(K_DELAY, $urandom_range(15), $urandom_range(3), d);
    else if (pick < 82) return make_op(K_TICK, $urandom_range(15), $urandom_range(3), d);
    else if (pick < 96) return make_op(K_YIELD, $urandom_range(15), $urandom_range(3), d);
    return make_op(K_SPARE + 3'($urandom_range(2)), $urandom_range(15), $urandom_range(3), d);
  endfunction

  task automatic drain();
    wait (op_queue.size() == 0 && !in_valid && sched_expected.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_step(logic [7:0] v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    tick_step = v;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [7:0] steps[8];
    for (int i = 0; i < NSLOT + 4; i++) begin
      link_nxt[i] = i;
      link_prv[i] = i;
    end
    foreach (slot_where[i]) begin
      slot_where[i] = WH_NONE;
      slot_level[i] = '0;
      slot_wake[i] = '0;
    end
    foreach (ring_len[i]) ring_len[i] = 0;
    cur_node = ROOT0;
    rings_dirty = 1'b1;
    ticks = '0;
    tick_step = 8'd1;
    steps = '{8'd1, 8'd255, 8'd0, 8'd3, 8'd1, 8'd255, 8'd7, 8'd2};

    repeat (10) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    // Directed opening: rejects, empty delay, wrap-around wake time, deletes.
    op_queue.push_back(make_op(K_DELAY, 0, 0, 32'd5));
    op_queue.push_back(make_op(K_YIELD, 0, 0, 0));
    op_queue.push_back(make_op(K_CREATE, 3, 3, 0));
    op_queue.push_back(make_op(K_DELETE, 7, 0, 0));
    op_queue.push_back(make_op(K_SPARE, 0, 0, 0));
    op_queue.push_back(make_op(K_SPARE + 3'd1, 0, 0, 0));
    op_queue.push_back(make_op(K_SPARE + 3'd2, 15, 3, 32'hFFFF_FFFF));
    op_queue.push_back(make_op(K_CREATE, 0, 0, 0));
    op_queue.push_back(make_op(K_CREATE, 15, 2, 0));
    op_queue.push_back(make_op(K_CREATE, 15, 1, 0));
    op_queue.push_back(make_op(K_CREATE, 5, 1, 0));
    op_queue.push_back(make_op(K_CREATE, 9, 2, 0));
    op_queue.push_back(make_op(K_YIELD, 0, 0, 0));
    op_queue.push_back(make_op(K_DELAY, 0, 0, 32'hFFFF_FFFF));
    op_queue.push_back(make_op(K_DELAY, 0, 0, 32'd0));
    op_queue.push_back(make_op(K_TICK, 0, 0, 0));
    op_queue.push_back(make_op(K_TICK, 0, 0, 0));
    op_queue.push_back(make_op(K_DELETE, 9, 0, 0));
    op_queue.push_back(make_op(K_DELETE, 15, 0, 0));
    op_queue.push_back(make_op(K_YIELD, 0, 0, 0));
    op_queue.push_back(make_op(K_DELAY, 0, 0, 32'h5555_AAAA));
    op_queue.push_back(make_op(K_DELETE, 5, 0, 0));
    op_queue.push_back(make_op(K_DELAY, 0, 0, 32'd1));
    op_queue.push_back(make_op(K_TICK, 0, 0, 0));
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_step(steps[ph]);
      case (ph % 4)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin sender_idle_pct = 6; recv_stall_pct = 6; end
      endcase
      for (int i = 0; i < 240; i++) op_queue.push_back(random_op());
      // The sender keeps offering while the receiver is held off.
      if (ph == 4) begin
        repeat (20) @(posedge clk);
        hold_req = 1;
      end
      drain();
    end

    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
